// File: rtl/core/wnps_pkg.sv
// shared types and constants for the wildcard nibble pattern scanner
`timescale 1ns / 1ps

package wnps_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int LEN_W       = 5;
  localparam int OUT_OFFSET_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_CARE    = 2'd1,
    REG_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// File: rtl/core/wildcard_nibble_pattern_scan.sv
// top level: byte stream scanner for a nibble pattern with wildcards
`timescale 1ns / 1ps

// Takes one byte per clock cycle and keeps the most recent (MAX_NIBBLES+1)/2
// bytes in a row of byte cells that shift each transfer; every cell compares
// its incoming byte against the pattern byte it lines up with, so the full
// window compare happens in the same cycle as the transfer. A result is held
// in an output register, and a new byte is taken whenever that register is
// empty or being read out, so the sustained rate is one byte per cycle; the
// result is valid in the cycle after the byte that completes a match (or ends
// the region). One result per region: found with the start offset of the
// first match, or not found on the byte marked is_last. Users must write
// pattern registers via the cfg port only while idle; nothing enforces it.

module wildcard_nibble_pattern_scan #(
  parameter int MAX_NIBBLES  = 16,
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wnps_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wnps_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           data_byte,
  input  logic                                 is_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 found,
  output logic [wnps_pkg::OUT_OFFSET_W-1:0]    match_offset
);

  localparam int WIN  = (MAX_NIBBLES + 1) / 2;
  localparam int NBW  = $clog2(WIN + 1);
  localparam int SUMW = (OFFSET_WIDTH >= 64) ? OFFSET_WIDTH : OFFSET_WIDTH + 1;
  localparam int OW   = wnps_pkg::OUT_OFFSET_W;

  logic [4*MAX_NIBBLES-1:0]     pattern_nibbles;
  logic [MAX_NIBBLES-1:0]       care_mask;
  logic [wnps_pkg::LEN_W-1:0]   pattern_length;

  logic [OFFSET_WIDTH-1:0]      bytes_seen;
  logic                         already_found;

  logic                         accept;
  wnps_pkg::cell_ctrl_t         cell_ctrl;
  logic [wnps_pkg::LEN_W-1:0]   nib;
  logic [NBW-1:0]               nbytes;
  logic [8*WIN-1:0]             pattern_pad;
  logic [2*WIN-1:0]             care_eff;
  logic [7:0]                   cell_byte [WIN];
  logic [WIN-1:0]               cell_match;
  logic [SUMW-1:0]              n_inc;
  logic                         seen_max;
  logic                         hit;
  logic                         emit;
  logic [OFFSET_WIDTH-1:0]      start;
  logic [OFFSET_WIDTH+OW-1:0]   start_ext;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_nibbles <= '0;
      care_mask       <= '0;
      pattern_length  <= '0;
    end else if (cfg_we) begin
      unique case (wnps_pkg::cfg_reg_t'(cfg_index))
        wnps_pkg::REG_PATTERN: pattern_nibbles <= cfg_data[4*MAX_NIBBLES-1:0];
        wnps_pkg::REG_CARE:    care_mask <= cfg_data[MAX_NIBBLES-1:0];
        wnps_pkg::REG_LENGTH:  pattern_length <= cfg_data[wnps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // pattern alignment
  always_comb begin
    nib = (pattern_length > wnps_pkg::LEN_W'(MAX_NIBBLES)) ?
          wnps_pkg::LEN_W'(MAX_NIBBLES) : pattern_length;
    nbytes = NBW'((nib + wnps_pkg::LEN_W'(1)) >> 1);
    pattern_pad = '0;
    pattern_pad[4*MAX_NIBBLES-1:0] = pattern_nibbles;
    for (int k = 0; k < 2*WIN; k++) begin
      care_eff[k] = (k < MAX_NIBBLES) && care_mask[k % MAX_NIBBLES] &&
                    (wnps_pkg::LEN_W'(k) < nib);
    end
  end

  assign in_ready        = !out_valid || out_ready;
  assign accept          = in_valid && in_ready;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.clear = accept && is_last;

  // window cells
  for (genvar i = 0; i < WIN; i++) begin : g_cell
    wnps_cell #(
      .INDEX (i),
      .WIN   (WIN),
      .NBW   (NBW)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .byte_in  ((i == 0) ? data_byte : cell_byte[(i == 0) ? 0 : i - 1]),
      .pattern  (pattern_pad),
      .care     (care_eff),
      .nbytes   (nbytes),
      .byte_out (cell_byte[i]),
      .match    (cell_match[i])
    );
  end

  // match decision and start offset
  always_comb begin
    n_inc    = SUMW'(bytes_seen) + SUMW'(1);
    seen_max = &bytes_seen;
    hit      = !already_found && (n_inc >= SUMW'(nbytes)) && (&cell_match);
    emit     = hit || (is_last && !already_found);
    if (nib == '0) begin
      start = '0;
    end else if (seen_max) begin
      start = '1;
    end else begin
      start = OFFSET_WIDTH'(n_inc - SUMW'(nbytes));
    end
    start_ext = {{OW{1'b0}}, start};
  end

  // region state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      already_found <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        bytes_seen    <= '0;
        already_found <= 1'b0;
      end else begin
        if (!seen_max) begin
          bytes_seen <= bytes_seen + OFFSET_WIDTH'(1);
        end
        already_found <= already_found || hit;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      found        <= hit;
      match_offset <= hit ? start_ext[OW-1:0] : '0;
    end
  end

  // checks
  a_nofind_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_offset == '0)
    else $error("not-found result with nonzero offset");

  a_region_end : assert property (@(posedge clk) disable iff (rst)
    accept && is_last |=> bytes_seen == '0 && !already_found)
    else $error("region state not cleared after last byte");

  a_single_hit : assert property (@(posedge clk) disable iff (rst)
    already_found |-> !hit)
    else $error("second match reported in one region");

  a_emit_slot : assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> out_valid)
    else $error("result lost after transfer");

endmodule

// File: rtl/core/wnps_cell.sv
// one window byte cell: holds a byte, compares the incoming byte, passes it on
`timescale 1ns / 1ps

module wnps_cell #(
  parameter int INDEX = 0,
  parameter int WIN   = 8,
  parameter int NBW   = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wnps_pkg::cell_ctrl_t   ctrl,
  input  logic [7:0]             byte_in,
  input  logic [8*WIN-1:0]       pattern,
  input  logic [2*WIN-1:0]       care,
  input  logic [NBW-1:0]         nbytes,
  output logic [7:0]             byte_out,
  output logic                   match
);

  logic [7:0] held;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      held <= '0;
    end else if (ctrl.shift) begin
      held <= byte_in;
    end
  end

  assign byte_out = held;

  // this cell sits at age INDEX, so it meets pattern byte nbytes-1-INDEX
  always_comb begin
    match = 1'b1;
    for (int j = 0; j < WIN; j++) begin
      if ((INDEX + 1 + j <= WIN) && (nbytes == NBW'(INDEX + 1 + j))) begin
        if (care[2*j] && (byte_in[7:4] != pattern[8*j+:4])) begin
          match = 1'b0;
        end
        if (care[2*j+1] && (byte_in[3:0] != pattern[8*j+4+:4])) begin
          match = 1'b0;
        end
      end
    end
  end

endmodule

// File: tb/wildcard_nibble_pattern_scan_tb.sv
// self-checking testbench for the wildcard nibble pattern scanner
`timescale 1ns / 1ps

module wildcard_nibble_pattern_scan_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BYTES = 2000;
  localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } scan_byte_t;

  typedef struct {
    logic        found;
    logic [31:0] offset;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [wnps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [wnps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [wnps_pkg::OUT_OFFSET_W-1:0] match_offset;

  wildcard_nibble_pattern_scan dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset)
  );

  scan_byte_t   bytes_pending [$];
  scan_result_t results_due [$];
  int           bytes_sent = 0;
  int           bytes_taken = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  bit           in_taken = 1'b0;
  bit           no_gaps = 1'b0;

  // scanner state as the testbench sees it
  logic [7:0]  win [8];
  logic [31:0] seen = '0;
  bit          hit_done = 1'b0;
  logic [63:0] cfg_pattern = '0;
  logic [15:0] cfg_care = '0;
  logic [4:0]  cfg_len = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pattern_nibble_count();
    return (cfg_len > 5'd16) ? 16 : int'(cfg_len);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic predict_scan(logic [7:0] b, logic last);
    int nib;
    int nbytes;
    bit hit;
    logic [7:0] wb;
    logic [3:0] have;
    scan_result_t res;
    for (int i = 7; i > 0; i--) win[i] = win[i-1];
    win[0] = b;
    if (!hit_done) begin
      nib = pattern_nibble_count();
      nbytes = (nib + 1) / 2;
      hit = (longint'(seen) + 1 >= nbytes);
      for (int k = 0; k < nib; k++) begin
        if (cfg_care[k]) begin
          wb = win[nbytes - 1 - k / 2];
          have = (k % 2) ? wb[3:0] : wb[7:4];
          if (have != cfg_pattern[4*k +: 4]) hit = 1'b0;
        end
      end
      if (hit) begin
        res.found = 1'b1;
        if (nib == 0) res.offset = '0;
        else if (seen == OFFSET_TOP) res.offset = OFFSET_TOP;
        else res.offset = seen + 1 - nbytes;
        results_due.insert(results_due.size(), res);
        hit_done = 1'b1;
      end
    end
    if (seen != OFFSET_TOP) seen = seen + 1;
    if (last) begin
      if (!hit_done) begin
        res.found = 1'b0;
        res.offset = '0;
        results_due.insert(results_due.size(), res);
      end
      foreach (win[i]) win[i] = '0;
      seen = '0;
      hit_done = 1'b0;
    end
  endtask

  task automatic check_result();
    scan_result_t want;
    if (results_due.size() == 0) begin
      report_mismatch($sformatf("result found=%0d offset=%0d with none due", found,
                                match_offset));
      return;
    end
    want = results_due.pop_front();
    if (found !== want.found)
      report_mismatch($sformatf("found %0d, expected %0d", found, want.found));
    if (match_offset !== want.offset)
      report_mismatch($sformatf("match_offset %0d, expected %0d", match_offset,
                                want.offset));
  endtask

  // sender and receiver
  always @(negedge clk) begin : drive
    scan_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (bytes_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
        nxt = bytes_pending.pop_front();
        in_valid <= 1'b1;
        data_byte <= nxt.data;
        is_last <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst ? 1'b0 : (no_gaps || $urandom_range(99) >= 36);
  end

  // transfer monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_scan(data_byte, is_last);
        bytes_taken++;
      end
      if (out_valid && out_ready) check_result();
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(wnps_pkg::cfg_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      wnps_pkg::REG_PATTERN: cfg_pattern = val;
      wnps_pkg::REG_CARE:    cfg_care = val[15:0];
      wnps_pkg::REG_LENGTH:  cfg_len = val[4:0];
      default:     ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_pattern(logic [63:0] pat, logic [15:0] care, logic [4:0] len);
    write_reg(wnps_pkg::REG_PATTERN, pat);
    write_reg(wnps_pkg::REG_CARE, {48'h0, care});
    write_reg(wnps_pkg::REG_LENGTH, {59'h0, len});
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    scan_byte_t item;
    item.data = b;
    item.last = last;
    bytes_pending.insert(bytes_pending.size(), item);
    bytes_sent++;
  endtask

  // wait until all bytes are taken and every result is in, then let the output register drain
  task automatic settle();
    do @(negedge clk); while (bytes_taken != bytes_sent || results_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [7:0] with_nibble(logic [7:0] b, int k, logic [3:0] v);
    return (k % 2) ? {b[7:4], v} : {v, b[3:0]};
  endfunction

  // mode 0: noise, 1: pattern embedded, 2: pattern embedded with one cared nibble wrong
  task automatic queue_region(int len, int mode);
    logic [7:0] body [$];
    int nib;
    int nb;
    int at;
    int k;
    logic [3:0] v;
    nib = pattern_nibble_count();
    nb = (nib + 1) / 2;
    for (int i = 0; i < len; i++) body.insert(body.size(), 8'($urandom));
    if (mode != 0 && nb > 0 && nb <= len) begin
      at = $urandom_range(len - nb);
      for (int j = 0; j < 2 * nb; j++) begin
        v = (j < nib && cfg_care[j]) ? cfg_pattern[4*j +: 4] : 4'($urandom);
        body[at + j/2] = with_nibble(body[at + j/2], j, v);
      end
      if (mode == 2 && (cfg_care & ((17'h1 << nib) - 1)) != 0) begin
        k = $urandom_range(nib - 1);
        while (!cfg_care[k]) k = (k + 1) % nib;
        v = (k % 2) ? body[at + k/2][3:0] : body[at + k/2][7:4];
        body[at + k/2] = with_nibble(body[at + k/2], k, v ^ 4'($urandom_range(1, 15)));
      end
    end
    for (int i = 0; i < len; i++) push_byte(body[i], i == len - 1);
  endtask

  initial begin : stimulus
    int phase;
    int phase_end;
    int r;
    logic [63:0] pat;
    logic [15:0] care;
    logic [4:0] len;
    foreach (win[i]) win[i] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // full length, all nibbles cared, all ones
    load_pattern(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd16);
    for (int i = 0; i < 8; i++) push_byte(8'hFF, i == 7);
    for (int i = 0; i < 3; i++) push_byte(8'hFF, i == 2);
    settle();

    // empty pattern; bytes after a match are ignored
    load_pattern(64'h0, 16'h0, 5'd0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    settle();

    // odd length, low nibble of last pattern byte not compared
    load_pattern(64'h0A5C, 16'hFFFF, 5'd3);
    push_byte(8'h12, 1'b0);
    push_byte(8'hC5, 1'b0);
    push_byte(8'hA7, 1'b1);
    settle();

    // oversized length, all wildcards
    load_pattern({$urandom, $urandom}, 16'h0000, 5'd31);
    for (int i = 0; i < 9; i++) push_byte(8'($urandom), i == 8);
    settle();

    phase = 0;
    while (bytes_sent < RANDOM_BYTES + 26) begin
      r = $urandom_range(9);
      len = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
            (r == 2) ? 5'd16 : 5'($urandom_range(1, 16));
      r = $urandom_range(7);
      care = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : 16'($urandom);
      r = $urandom_range(9);
      pat = (r == 0) ? 64'h0 : (r == 1) ? '1 : {$urandom, $urandom};
      load_pattern(pat, care, len);
      no_gaps = (phase == 3);
      phase_end = bytes_sent + $urandom_range(120, 250);
      while (bytes_sent < phase_end) begin
        r = $urandom_range(9);
        queue_region(($urandom_range(9) == 0) ? $urandom_range(25, 60) :
                     $urandom_range(1, 20), (r < 6) ? 1 : (r < 8) ? 2 : 0);
      end
      // leave a region open so the next settings land mid-region
      if ($urandom_range(1)) begin
        r = $urandom_range(1, 6);
        for (int i = 0; i < r; i++) push_byte(8'($urandom), 1'b0);
      end
      settle();
      phase++;
    end
    push_byte(8'($urandom), 1'b1);
    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
